// ===== hw/rtl/dclv_pkg.sv =====
// ----------------------------------------------------------------------------
// dclv_pkg
// Shared types and constants of the DC-link voltage loop.
// ----------------------------------------------------------------------------
package dclv_pkg;

  localparam int unsigned PHASES     = 3;
  localparam int unsigned IDX_W      = 2;
  localparam int unsigned VOLT_W     = 24;
  localparam int unsigned AMP_W      = 23;
  localparam int unsigned INT_W      = 32;
  localparam int unsigned EV_W       = 25;
  localparam int unsigned PROD_W     = 49;
  localparam int unsigned IPART_W    = 33;
  localparam int unsigned INC_W      = 57;
  localparam int unsigned SUM_W      = 34;
  localparam int unsigned STEP_W     = 23;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned PER_W      = 24;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_W      = 24;
  localparam int unsigned CFG_AW     = 3;
  localparam int unsigned IN_DATA_W  = 152;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned OUT_USER_W = 3;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned PER_FRAC_W = 24;

  localparam logic [CFG_AW-1:0] REG_TARGET  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_RAMP    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_PERIOD  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_LIMIT   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_PGAIN   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_IGAIN   = 3'd5;
  localparam logic [CFG_AW-1:0] REG_MODE    = 3'd6;
  localparam logic [CFG_AW-1:0] REG_TPHASE  = 3'd7;

  localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ALL    = 2'd2;

  typedef enum logic [2:0] {
    STG_NONE,
    STG_REF,
    STG_ERR,
    STG_MUL,
    STG_INC,
    STG_CAND,
    STG_COMMIT,
    STG_AMP
  } stg_e;

  typedef struct packed {
    logic meas;
    logic en;
    stg_e stage;
  } lane_ctl_t;

  typedef struct packed {
    logic [VOLT_W-2:0] target;
    logic [AMP_W-1:0]  limit;
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [PER_W-1:0]  period;
    logic [STEP_W-1:0] step;
  } lane_cfg_t;

  typedef struct packed {
    logic              act;
    logic [VOLT_W-1:0] ref_volt;
    logic [AMP_W-1:0]  amp;
  } lane_res_t;

endpackage

// ===== hw/rtl/dclv_lane.sv =====
// ----------------------------------------------------------------------------
// dclv_lane
// One phase: average, takeover, ramped reference and PI with anti-windup.
// ----------------------------------------------------------------------------
module dclv_lane import dclv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lane_ctl_t                ctl_i,
  input  lane_cfg_t                cfg_i,
  input  logic signed [VOLT_W-1:0] volt_hi_i,
  input  logic signed [VOLT_W-1:0] volt_lo_i,
  output lane_res_t                res_o
);

  logic signed [VOLT_W-1:0]   avg_q, ref_q;
  logic signed [INT_W-1:0]    integ_q, cand_q;
  logic [AMP_W-1:0]           amp_q;
  logic                       act_q, run_q;
  logic signed [EV_W-1:0]     ev_q;
  logic signed [PROD_W-1:0]   prodp_q, prodi_q;
  logic signed [INC_W-1:0]    inc_q;

  logic signed [VOLT_W:0]     sum_hl, ref_up, ref_dn, tgt_s, ref_s;
  logic signed [VOLT_W-1:0]   avg_d, ref_d;
  logic signed [EV_W-1:0]     ev_d;
  logic signed [PROD_W:0]     prodp_full, prodi_full;
  logic signed [INC_W:0]      inc_full;
  logic signed [SUM_W-1:0]    cand_full, prop_s, outc, amp_full, lim_s;
  logic signed [INT_W-1:0]    cand_d;
  logic                       ev_pos, ev_neg, hold;
  logic [AMP_W-1:0]           amp_d;

  always_comb begin
    sum_hl = {volt_hi_i[VOLT_W-1], volt_hi_i} + {volt_lo_i[VOLT_W-1], volt_lo_i};
    avg_d  = sum_hl[VOLT_W:1];

    ref_s  = {ref_q[VOLT_W-1], ref_q};
    tgt_s  = $signed({2'b00, cfg_i.target});
    ref_up = ref_s + $signed({2'b00, cfg_i.step});
    ref_dn = ref_s - $signed({2'b00, cfg_i.step});
    if (ref_s < tgt_s) begin
      ref_d = (ref_up > tgt_s) ? tgt_s[VOLT_W-1:0] : ref_up[VOLT_W-1:0];
    end else if (ref_s > tgt_s) begin
      ref_d = (ref_dn < tgt_s) ? tgt_s[VOLT_W-1:0] : ref_dn[VOLT_W-1:0];
    end else begin
      ref_d = ref_q;
    end

    ev_d = {ref_q[VOLT_W-1], ref_q} - {avg_q[VOLT_W-1], avg_q};

    prodp_full = $signed({1'b0, cfg_i.prop_gain}) * ev_q;
    prodi_full = $signed({1'b0, cfg_i.integ_gain}) * ev_q;
    inc_full   = $signed(prodi_q[PROD_W-1:FRAC_W]) * $signed({1'b0, cfg_i.period});

    // saturate integrator candidate to 32 bits
    cand_full = {{2{integ_q[INT_W-1]}}, integ_q}
              + {inc_q[INC_W-1], inc_q[INC_W-1:PER_FRAC_W]};
    if (cand_full[SUM_W-1:INT_W-1] == '0 || cand_full[SUM_W-1:INT_W-1] == '1) begin
      cand_d = cand_full[INT_W-1:0];
    end else if (cand_full[SUM_W-1]) begin
      cand_d = {1'b1, {(INT_W-1){1'b0}}};
    end else begin
      cand_d = {1'b0, {(INT_W-1){1'b1}}};
    end

    prop_s = {prodp_q[PROD_W-1], prodp_q[PROD_W-1:FRAC_W]};
    lim_s  = $signed({{(SUM_W-AMP_W){1'b0}}, cfg_i.limit});
    outc   = prop_s + {{2{cand_q[INT_W-1]}}, cand_q};
    ev_pos = !ev_q[EV_W-1] && (ev_q != '0);
    ev_neg = ev_q[EV_W-1];
    hold   = ((outc > lim_s) && ev_pos) || ((outc < 0) && ev_neg);

    amp_full = prop_s + {{2{integ_q[INT_W-1]}}, integ_q};
    if (amp_full < 0) begin
      amp_d = '0;
    end else if (amp_full > lim_s) begin
      amp_d = cfg_i.limit;
    end else begin
      amp_d = amp_full[AMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q   <= '0;
      ref_q   <= '0;
      integ_q <= '0;
      amp_q   <= '0;
      act_q   <= 1'b0;
      run_q   <= 1'b0;
    end else if (ctl_i.meas) begin
      avg_q <= avg_d;
      if (!ctl_i.en) begin
        integ_q <= '0;
        amp_q   <= '0;
        act_q   <= 1'b0;
      end else if (!act_q) begin
        ref_q   <= avg_d;
        integ_q <= '0;
        amp_q   <= '0;
        act_q   <= 1'b1;
      end
    end else begin
      unique case (ctl_i.stage)
        STG_REF: begin
          if (!ctl_i.en) begin
            integ_q <= '0;
            amp_q   <= '0;
            act_q   <= 1'b0;
            run_q   <= 1'b0;
          end else begin
            run_q <= act_q;
            if (act_q) begin
              ref_q <= ref_d;
            end
          end
        end
        STG_COMMIT: begin
          if (run_q && !hold) begin
            integ_q <= cand_q;
          end
        end
        STG_AMP: begin
          if (run_q) begin
            amp_q <= amp_d;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (ctl_i.stage)
      STG_ERR:  ev_q <= ev_d;
      STG_MUL: begin
        prodp_q <= prodp_full[PROD_W-1:0];
        prodi_q <= prodi_full[PROD_W-1:0];
      end
      STG_INC:  inc_q  <= inc_full[INC_W-1:0];
      STG_CAND: cand_q <= cand_d;
      default: begin
      end
    endcase
  end

  assign res_o.act      = act_q;
  assign res_o.ref_volt = ref_q;
  assign res_o.amp      = amp_q;

endmodule

// ===== hw/rtl/dclv_merge.sv =====
// ----------------------------------------------------------------------------
// dclv_merge
// Picks one lane result per word and holds it in the output register.
// ----------------------------------------------------------------------------
module dclv_merge import dclv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lane_res_t             res_i [PHASES],
  input  logic                  load_i,
  input  logic [IDX_W-1:0]      sel_i,
  input  logic                  ready_i,
  output logic                  valid_o,
  output logic [OUT_DATA_W-1:0] data_o,
  output logic [OUT_USER_W-1:0] user_o,
  output logic                  last_o,
  output logic                  free_o
);

  lane_res_t             pick;
  logic                  valid_q;
  logic [OUT_DATA_W-1:0] data_q;
  logic [OUT_USER_W-1:0] user_q;
  logic                  last_q;

  always_comb begin
    pick = '0;
    for (int p = 0; p < PHASES; p++) begin
      if (sel_i == IDX_W'(p)) begin
        pick = res_i[p];
      end
    end
  end

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= {1'b0, pick.ref_volt, pick.amp};
      user_q <= {pick.act, sel_i};
      last_q <= (sel_i == IDX_W'(PHASES - 1));
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign user_o  = user_q;
  assign last_o  = last_q;

endmodule

// ===== hw/rtl/dc_link_voltage_pi_ramp.sv =====
// ----------------------------------------------------------------------------
// dc_link_voltage_pi_ramp
// Three-phase DC-link voltage loop with slewed setpoint and anti-windup PI.
// ----------------------------------------------------------------------------
// A measure word (tuser 0) is taken directly: every phase lane stores its
// capacitor average, and a disabled lane is reset and an enabled idle lane
// taken over at once. A tick word (tuser 1) runs all lanes together through
// a sequence (ramp, error, gain multiply, period multiply, saturate, commit,
// clamp) and then sends one word per phase, phase A first, tlast on phase C.
// Input is taken only between ticks; the last output word may still wait
// while the next input word is accepted. All configuration registers reset
// to zero; write them only while idle.
module dc_link_voltage_pi_ramp import dclv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_AW-1:0]     cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // enable, volt_a_upper, volt_a_lower, volt_b_upper, volt_b_lower,
  // volt_c_upper, volt_c_lower, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // current_amplitude, ramp_reference, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // phase number, active flag
  output logic [OUT_USER_W-1:0] m_axis_tuser,
  output logic                  m_axis_tlast
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_e;

  state_e             state_q;
  stg_e               stg_q;
  logic [IDX_W-1:0]   idx_q;
  logic               tick_en_q;
  logic [STEP_W-1:0]  step_q;
  logic [VOLT_W-2:0]  target_q;
  logic [STEP_W-1:0]  ramp_q;
  logic [PER_W-1:0]   period_q;
  logic [AMP_W-1:0]   limit_q;
  logic [GAIN_W-1:0]  pgain_q, igain_q;
  logic [MODE_W-1:0]  mode_q, tphase_q;

  logic                      accept, kind, enable, load, free;
  logic [STEP_W+PER_W-1:0]   step_prod;
  lane_cfg_t                 lcfg;
  lane_res_t                 res [PHASES];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign kind          = s_axis_tuser[0];
  assign enable        = s_axis_tdata[0];
  assign step_prod     = ramp_q * period_q;
  assign load          = (state_q == S_OUT) && free;

  assign lcfg.target     = target_q;
  assign lcfg.limit      = limit_q;
  assign lcfg.prop_gain  = pgain_q;
  assign lcfg.integ_gain = igain_q;
  assign lcfg.period     = period_q;
  assign lcfg.step       = step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      ramp_q   <= '0;
      period_q <= '0;
      limit_q  <= '0;
      pgain_q  <= '0;
      igain_q  <= '0;
      mode_q   <= '0;
      tphase_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_TARGET: target_q <= cfg_data_i[VOLT_W-2:0];
        REG_RAMP:   ramp_q   <= cfg_data_i[STEP_W-1:0];
        REG_PERIOD: period_q <= cfg_data_i[PER_W-1:0];
        REG_LIMIT:  limit_q  <= cfg_data_i[AMP_W-1:0];
        REG_PGAIN:  pgain_q  <= cfg_data_i[GAIN_W-1:0];
        REG_IGAIN:  igain_q  <= cfg_data_i[GAIN_W-1:0];
        REG_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
        REG_TPHASE: tphase_q <= cfg_data_i[MODE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      stg_q     <= STG_NONE;
      idx_q     <= '0;
      tick_en_q <= 1'b0;
      step_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept && kind) begin
            tick_en_q <= enable;
            step_q    <= step_prod[STEP_W+PER_W-1:PER_W];
            stg_q     <= STG_REF;
            state_q   <= S_RUN;
          end
        end
        S_RUN: begin
          unique case (stg_q)
            STG_REF:    stg_q <= STG_ERR;
            STG_ERR:    stg_q <= STG_MUL;
            STG_MUL:    stg_q <= STG_INC;
            STG_INC:    stg_q <= STG_CAND;
            STG_CAND:   stg_q <= STG_COMMIT;
            STG_COMMIT: stg_q <= STG_AMP;
            default: begin
              stg_q   <= STG_NONE;
              idx_q   <= '0;
              state_q <= S_OUT;
            end
          endcase
        end
        default: begin
          if (free) begin
            if (idx_q == IDX_W'(PHASES - 1)) begin
              state_q <= S_IDLE;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
      endcase
    end
  end

  for (genvar p = 0; p < PHASES; p++) begin : g_lane
    lane_ctl_t ctl;
    logic      mode_ok;

    assign mode_ok   = (mode_q == MODE_ALL)
                    || ((mode_q == MODE_SINGLE) && (tphase_q == MODE_W'(p)));
    assign ctl.meas  = accept && !kind;
    assign ctl.en    = (ctl.meas ? enable : tick_en_q) && mode_ok;
    assign ctl.stage = stg_q;

    dclv_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .cfg_i     (lcfg),
      .volt_hi_i (s_axis_tdata[1 + 2*VOLT_W*p +: VOLT_W]),
      .volt_lo_i (s_axis_tdata[1 + 2*VOLT_W*p + VOLT_W +: VOLT_W]),
      .res_o     (res[p])
    );
  end

  dclv_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .load_i  (load),
    .sel_i   (idx_q),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (m_axis_tdata),
    .user_o  (m_axis_tuser),
    .last_o  (m_axis_tlast),
    .free_o  (free)
  );

endmodule
